### hw/rtl/slab_bitmap_slot_allocator_unit_defines.svh
// Assertion helpers for the allocator RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef SLAB_BITMAP_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define SLAB_BITMAP_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/sbsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbsa_pkg;

	localparam int unsigned BitmapWordsDef = 64;
	localparam int unsigned PageBytes      = 4096;

	localparam int unsigned OffsetW  = 12;
	localparam int unsigned CountW   = 12;
	localparam int unsigned OrderW   = 4;
	localparam int unsigned CfgIdxW  = 1;
	localparam int unsigned CfgDataW = 12;

	localparam logic [CountW-1:0] ObjectsReset = 12'd64;
	localparam logic [OrderW-1:0] OrderReset   = 4'd0;

	localparam logic [CfgIdxW-1:0] CFG_OBJECTS = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_ORDER   = 1'b1;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef struct packed {
		logic capture;
		logic scan;
		logic pick;
		logic modify;
		logic load_out;
	} sbsa_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} sbsa_stat_t;

endpackage

`default_nettype wire

### hw/rtl/slab_bitmap_slot_allocator_unit.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: free_offset; tuser: func
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: offset, full, empty; tuser: granted
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// An allocate goes through accept, group summary, word pick and
// bitmap read, read-modify-write and status reduction; a free skips the
// group summary. A new item is accepted only once the last has left status.
// The bitmap is a 64-bit wide memory with two read ports (chosen word and
// boundary word). Reset marks every word invalid, so it reads as free; there
// is no clearing pass. Configuration resets to 64 objects of order 0.
// The result register holds a result until its transfer; the next item is
// accepted meanwhile, and the sequencer waits in its last step if still held.
`timescale 1ns / 1ps
`default_nettype none

module slab_bitmap_slot_allocator_unit
	import sbsa_pkg::*;
#(
	parameter int unsigned STORE_WORDS = BitmapWordsDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [15:0]         s_axis_tdata,  // [11:0] free_offset
	input  wire logic [0:0]          s_axis_tuser,  // [0] func
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [15:0]              m_axis_tdata,  // [11:0] object_offset, [12] slab_full,
	                                                // [13] slab_empty
	output logic [0:0]               m_axis_tuser,  // [0] granted
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	sbsa_cmd_t          cmd;
	sbsa_stat_t         stat;
	logic               out_granted;
	logic [OffsetW-1:0] out_offset;
	logic               out_full;
	logic               out_empty;

	sbsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_func  (s_axis_tuser[0]),
		.cmd      (cmd),
		.stat     (stat)
	);

	sbsa_dp #(
		.STORE_WORDS (STORE_WORDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_func     (s_axis_tuser[0]),
		.in_offset   (s_axis_tdata[OffsetW-1:0]),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_granted (out_granted),
		.out_offset  (out_offset),
		.out_full    (out_full),
		.out_empty   (out_empty)
	);

	assign m_axis_tdata = {2'b00, out_empty, out_full, out_offset};
	assign m_axis_tuser = out_granted;

endmodule

`default_nettype wire

### hw/rtl/sbsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "slab_bitmap_slot_allocator_unit_defines.svh"

module sbsa_ctrl
	import sbsa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       in_func,
	output sbsa_cmd_t       cmd,
	input  wire sbsa_stat_t stat
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_PICK   = 5'b00100,
		ST_MODIFY = 5'b01000,
		ST_STATUS = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd.capture  = accept;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.pick     = (state_q == ST_PICK);
		cmd.modify   = (state_q == ST_MODIFY);
		cmd.load_out = (state_q == ST_STATUS) && !stat.out_blocked;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// A free goes straight to the word read; only allocates search.
					state_d = (in_func == FUNC_FREE) ? ST_PICK : ST_SCAN;
				end
			end
			ST_SCAN:   state_d = ST_PICK;
			ST_PICK:   state_d = ST_MODIFY;
			ST_MODIFY: state_d = ST_STATUS;
			ST_STATUS: begin
				if (!stat.out_blocked) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SBSA_ASSERT_NEXT(a_alloc_scans, accept && (in_func == FUNC_ALLOC), state_q == ST_SCAN, "allocate did not start the search")
	`SBSA_ASSERT_NEXT(a_free_reads, accept && (in_func == FUNC_FREE), state_q == ST_PICK, "free did not go to the word read")
	`SBSA_ASSERT_NEXT(a_modify_then_status, state_q == ST_MODIFY, state_q == ST_STATUS, "status step skipped after update")
	`SBSA_ASSERT_NOW(a_no_overwrite, cmd.load_out, !stat.out_blocked, "result register overwritten while held")

endmodule

`default_nettype wire

### hw/rtl/sbsa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sbsa_dp
	import sbsa_pkg::*;
#(
	parameter int unsigned STORE_WORDS = BitmapWordsDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                in_func,
	input  wire logic [OffsetW-1:0]  in_offset,
	input  wire sbsa_cmd_t           cmd,
	output sbsa_stat_t               stat,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     out_granted,
	output logic [OffsetW-1:0]       out_offset,
	output logic                     out_full,
	output logic                     out_empty
);

	localparam int unsigned WordW       = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int unsigned NGrp        = (STORE_WORDS + 7) / 8;
	localparam int unsigned GrpW        = (NGrp > 1) ? $clog2(NGrp) : 1;
	localparam int unsigned StoreSlots  = STORE_WORDS * 64;

	function automatic logic [5:0] ffs64(input logic [63:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) begin
				r = 6'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [2:0] ffs8(input logic [7:0] v);
		logic [2:0] r;
		r = '0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	// Configuration registers.
	logic [CountW-1:0] objects_q;
	logic [OrderW-1:0] order_q;

	// Item registers.
	logic              func_q;
	logic [11:0]       slot_q;
	logic [11:0]       lim_q;

	// Bitmap storage and per-word summary.
	logic [63:0]             mem_q [STORE_WORDS];
	logic [STORE_WORDS-1:0]  vld_q;
	logic [STORE_WORDS-1:0]  all_set_q;
	logic [STORE_WORDS-1:0]  any_set_q;

	logic [NGrp-1:0]   grp_q;
	logic [WordW-1:0]  wsel_q;
	logic              cand_q;
	logic [63:0]       rd_a_q;
	logic [63:0]       rd_b_q;
	logic              rd_a_vld_q;
	logic              rd_b_vld_q;
	logic [63:0]       bnd_q;
	logic              granted_q;
	logic [OffsetW-1:0] offset_q;
	logic              out_valid_q;

	logic [16:0]        page_slots;
	logic [16:0]        lim17;
	logic [5:0]         bword;
	logic [5:0]         bbits;
	logic [63:0]        bmask;
	logic [STORE_WORDS-1:0] below_w;
	logic [NGrp*8-1:0]  word_avail;
	logic [GrpW-1:0]    gidx;
	logic               grp_any;
	logic [2:0]         widx;
	logic [GrpW+2:0]    pick_word;
	logic               store_hit;
	logic [WordW-1:0]   wsel_c;
	logic               cand_c;
	logic [WordW-1:0]   bnd_idx;
	logic [63:0]        wa;
	logic [63:0]        wb;
	logic               is_bnd;
	logic [63:0]        avail;
	logic               alloc_hit;
	logic [5:0]         bit_sel;
	logic [63:0]        new_word;
	logic [WordW+5:0]   sel_slot;
	logic               full_c;
	logic               empty_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			objects_q <= ObjectsReset;
			order_q   <= OrderReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OBJECTS: objects_q <= cfg_data;
				CFG_ORDER:   order_q   <= cfg_data[OrderW-1:0];
				default:     ;
			endcase
		end
	end

	// Usable slots: below the object count, inside the page and inside the storage.
	always_comb begin
		page_slots = 17'(PageBytes) >> order_q;
		lim17      = {5'b0, objects_q};
		if (page_slots < lim17) begin
			lim17 = page_slots;
		end
		if (17'(StoreSlots) < lim17) begin
			lim17 = 17'(StoreSlots);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_func;
			slot_q <= in_offset >> order_q;
			lim_q  <= lim17[11:0];
		end
	end

	assign bword = lim_q[11:6];
	assign bbits = lim_q[5:0];
	assign bmask = (bbits == 6'd0) ? 64'd0 : ((64'd1 << bbits) - 64'd1);

	always_comb begin
		for (int w = 0; w < STORE_WORDS; w++) begin
			below_w[w] = (7'(w) < {1'b0, bword});
		end
	end

	// Words wholly below the boundary that still hold a free slot.
	always_comb begin
		word_avail = '0;
		for (int w = 0; w < STORE_WORDS; w++) begin
			word_avail[w] = !all_set_q[w] && below_w[w];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			for (int g = 0; g < NGrp; g++) begin
				grp_q[g] <= |word_avail[g*8 +: 8];
			end
		end
	end

	always_comb begin
		gidx = '0;
		for (int g = NGrp - 1; g >= 0; g--) begin
			if (grp_q[g]) begin
				gidx = GrpW'(g);
			end
		end
	end

	assign grp_any   = |grp_q;
	assign widx      = ffs8(word_avail[gidx*8 +: 8]);
	assign pick_word = {gidx, widx};
	assign store_hit = ({1'b0, slot_q} < 13'(StoreSlots));
	assign bnd_idx   = (bbits != 6'd0) ? WordW'(bword) : '0;

	always_comb begin
		if (func_q == FUNC_FREE) begin
			cand_c = store_hit;
			wsel_c = store_hit ? WordW'(slot_q[11:6]) : '0;
		end else if (grp_any) begin
			cand_c = 1'b1;
			wsel_c = WordW'(pick_word);
		end else begin
			// Only the partial word at the boundary can still have a free slot.
			cand_c = (bbits != 6'd0);
			wsel_c = bnd_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			wsel_q     <= wsel_c;
			cand_q     <= cand_c;
			rd_a_q     <= mem_q[wsel_c];
			rd_b_q     <= mem_q[bnd_idx];
			rd_a_vld_q <= vld_q[wsel_c];
			rd_b_vld_q <= vld_q[bnd_idx];
		end
		if (cmd.modify && cand_q) begin
			mem_q[wsel_q] <= new_word;
		end
	end

	// A word never written reads as all free.
	assign wa     = rd_a_vld_q ? rd_a_q : 64'd0;
	assign wb     = rd_b_vld_q ? rd_b_q : 64'd0;
	assign is_bnd = (bbits != 6'd0) && (6'(wsel_q) == bword);
	assign avail  = ~wa & (is_bnd ? bmask : {64{1'b1}});
	assign bit_sel = ffs64(avail);

	// The boundary word may have no usable free bit left, so a candidate is not yet a grant.
	assign alloc_hit = (func_q == FUNC_ALLOC) && cand_q && (avail != 64'd0);

	always_comb begin
		if (func_q == FUNC_FREE) begin
			new_word = wa & ~(64'd1 << slot_q[5:0]);
		end else begin
			new_word = wa | (64'd1 << bit_sel);
		end
	end

	assign sel_slot = {wsel_q, bit_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			all_set_q <= '0;
			any_set_q <= '0;
		end else if (cmd.modify && cand_q) begin
			vld_q[wsel_q]     <= 1'b1;
			all_set_q[wsel_q] <= &new_word;
			any_set_q[wsel_q] <= |new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.modify) begin
			bnd_q     <= (cand_q && is_bnd) ? new_word : wb;
			granted_q <= alloc_hit;
			if (alloc_hit) begin
				offset_q <= OffsetW'(sel_slot) << order_q;
			end else begin
				offset_q <= '0;
			end
		end
	end

	assign full_c  = (&(all_set_q | ~below_w)) && ((~bnd_q & bmask) == 64'd0);
	assign empty_c = !(|(any_set_q & below_w)) && ((bnd_q & bmask) == 64'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_granted <= granted_q;
			out_offset  <= offset_q;
			out_full    <= full_c;
			out_empty   <= empty_c;
		end
	end

	assign out_valid        = out_valid_q;
	assign stat.out_blocked = out_valid_q && !out_ready;

endmodule

`default_nettype wire
